### rtl/are_pkg.sv
// ----------------------------------------------------------------------------
// Arrhenius rate evaluator package
// Shared widths, constants and register codes for the rate evaluator.
// ----------------------------------------------------------------------------
package are_pkg;

    // Barrier scale factors in Q16.16.
    localparam int unsigned ONE_Q16           = 65536;
    localparam int unsigned MEV_TO_KELVIN_Q16 = 760514;
    localparam int          CQ_W              = 20;

    // ln 2 in Q0.32.
    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

    // Taylor series length for exp(-f).
    localparam int N_TERMS = 14;

    // Quotient widths of the two divider chains and the exponent width.
    localparam int DIV1_QW = 37;
    localparam int DIV2_QW = 48;
    localparam int X_W     = 37;
    localparam int N_W     = 6;

    // Reduction steps for x / ln 2 (n stays below 47).
    localparam int RED_STEPS = 6;

    // Cycles from an accepted word to its result strobe.
    localparam int LATENCY = 4 + DIV1_QW + RED_STEPS + 3 * N_TERMS + 3 + DIV2_QW;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_ATTEMPT_RATE   = 2'd0,
        CFG_BARRIER_ENERGY = 2'd1,
        CFG_UNIT_MEV       = 2'd2
    } t_cfg_idx;

endpackage

### rtl/are_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: brings down one dividend bit, subtracts the
// divisor when it fits, and shifts the quotient bit into the word.
// ----------------------------------------------------------------------------
module are_div_cell #(
    parameter int QW = 37,
    parameter int SW = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [31:0]   i_rem,
    input  logic [31:0]   i_div,
    input  logic [QW-1:0] i_word,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [31:0]   o_rem,
    output logic [31:0]   o_div,
    output logic [QW-1:0] o_word,
    output logic [SW-1:0] o_side
);

    logic [32:0]   rem2;
    logic [32:0]   diff;
    logic          ge;
    logic [31:0]   n_rem;
    logic [QW-1:0] n_word;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb begin
        rem2   = {i_rem, i_word[QW-1]};
        diff   = rem2 - {1'b0, i_div};
        ge     = (rem2 >= {1'b0, i_div});
        n_rem  = ge ? diff[31:0] : rem2[31:0];
        n_word = {i_word[QW-2:0], ge};
    end

    // Valid bit of the cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    // Payload handed to the next cell.
    always_ff @(posedge i_clk) begin
        o_rem  <= n_rem;
        o_div  <= i_div;
        o_word <= n_word;
        o_side <= i_side;
    end

endmodule

### rtl/are_red_cell.sv
// ----------------------------------------------------------------------------
// Range reduction cell
// One step of x mod ln 2: subtracts ln 2 shifted by J when it fits and
// records the bit of n.
// ----------------------------------------------------------------------------
module are_red_cell #(
    parameter int J  = 0,
    parameter int SW = 34
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [are_pkg::X_W-1:0] i_x,
    input  logic [are_pkg::N_W-1:0] i_n,
    input  logic [SW-1:0]           i_side,
    output logic                    o_valid,
    output logic [are_pkg::X_W-1:0] o_x,
    output logic [are_pkg::N_W-1:0] o_n,
    output logic [SW-1:0]           o_side
);

    localparam logic [are_pkg::X_W-1:0] STEP =
        are_pkg::X_W'(64'(are_pkg::LN2_Q32) << J);

    logic ge;

    // Compare against the shifted constant.
    assign ge = (i_x >= STEP);

    // Valid bit of the cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    // Payload handed to the next cell.
    always_ff @(posedge i_clk) begin
        o_x    <= ge ? (i_x - STEP) : i_x;
        o_n    <= {i_n[are_pkg::N_W-2:0], ge};
        o_side <= i_side;
    end

endmodule

### rtl/are_series_cell.sv
// ----------------------------------------------------------------------------
// Series cell
// One term of the alternating Taylor series of exp(-f): multiplies the last
// term by f, divides by K through a reciprocal with a correction, and adds
// or subtracts the new term. Three register stages.
// ----------------------------------------------------------------------------
module are_series_cell #(
    parameter int K  = 1,
    parameter int SW = 40
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [31:0]   i_f,
    input  logic [32:0]   i_term,
    input  logic [32:0]   i_sum,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [31:0]   o_f,
    output logic [32:0]   o_term,
    output logic [32:0]   o_sum,
    output logic [SW-1:0] o_side
);

    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);
    localparam logic [35:0] K1    = 36'(K);
    localparam logic [35:0] K2    = 36'(2 * K);

    logic [64:0]   prod_a;
    logic [64:0]   prod_b;
    logic [35:0]   kq;
    logic [35:0]   remv;
    logic [31:0]   q;

    logic          r_a_valid, r_b_valid;
    logic [31:0]   r_a_v, r_b_v, r_b_q0;
    logic [31:0]   r_a_f, r_b_f;
    logic [32:0]   r_a_sum, r_b_sum;
    logic [SW-1:0] r_a_side, r_b_side;

    // Term times f, then the estimate of the quotient by K.
    always_comb begin
        prod_a = 65'(i_term) * 65'(i_f);
        prod_b = 65'(r_a_v) * 65'(RECIP);
    end

    // Correct the estimate so that the quotient is exact.
    always_comb begin
        kq   = 36'(r_b_q0) * K1;
        remv = 36'(r_b_v) - kq;
        if (remv >= K2) begin
            q = r_b_q0 + 32'd2;
        end else if (remv >= K1) begin
            q = r_b_q0 + 32'd1;
        end else begin
            q = r_b_q0;
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            o_valid   <= r_b_valid;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        r_a_v    <= prod_a[63:32];
        r_a_f    <= i_f;
        r_a_sum  <= i_sum;
        r_a_side <= i_side;

        r_b_q0   <= prod_b[63:32];
        r_b_v    <= r_a_v;
        r_b_f    <= r_a_f;
        r_b_sum  <= r_a_sum;
        r_b_side <= r_a_side;

        o_term   <= {1'b0, q};
        o_f      <= r_b_f;
        o_sum    <= (K % 2 == 1) ? (r_b_sum - 33'(q)) : (r_b_sum + 33'(q));
        o_side   <= r_b_side;
    end

endmodule

### rtl/arrhenius_rate_evaluator.sv
// ----------------------------------------------------------------------------
// Arrhenius rate evaluator
// Computes A*exp(-c*B/T) and its derivatives by A and by B for a stream of
// temperature samples, through a chain of divider, reduction and series
// cells.
// ----------------------------------------------------------------------------
// Usage:
//   A temperature word is taken at a rising edge with i_start high and
//   o_busy low. Its result shows on the result ports with o_valid high for
//   exactly one cycle; the receiver cannot stall it. A new word may be
//   started in every cycle, so the sustained rate is one word per cycle,
//   and results leave in order. The pipeline is the cell chain: 37 divider
//   cells for B*c/T, 6 reduction cells for the ln 2 split, 14 series cells
//   of 3 stages each, 48 divider cells for the barrier slope, plus 7 stages
//   of multipliers and boundary registers. Registers are written through
//   i_cfg_we / i_cfg_index / i_cfg_data; the user must write them only
//   while no word is in flight, and the block itself has no check for
//   this. Index 0 is the prefactor, 1 the barrier, 2 the meV unit select,
//   and index 3 is ignored.
//   Reset is synchronous: it restores the register defaults, drops all
//   words in flight and holds o_busy high until the cycle after release.
// ----------------------------------------------------------------------------
module arrhenius_rate_evaluator #(
    parameter int unsigned MEV_TO_KELVIN_Q16 = are_pkg::MEV_TO_KELVIN_Q16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [31:0]        i_temperature,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    output logic [31:0]        o_rate_value,
    output logic [31:0]        o_exp_factor,
    output logic signed [47:0] o_barrier_slope,
    output logic               o_zero_temp_flag
);

    localparam int Q1 = are_pkg::DIV1_QW;
    localparam int Q2 = are_pkg::DIV2_QW;
    localparam int NR = are_pkg::RED_STEPS;
    localparam int NT = are_pkg::N_TERMS;
    localparam int XW = are_pkg::X_W;
    localparam int NW = are_pkg::N_W;
    localparam int CW = are_pkg::CQ_W;
    localparam int RSW = 34;
    localparam int SSW = NW + 34;
    localparam int DSW = 66;

    // Configuration registers and start gating.
    logic [31:0]   r_attempt_rate;
    logic [31:0]   r_barrier_energy;
    logic          r_unit_mev;
    logic          r_live;
    logic [CW-1:0] cq;
    logic          accept;

    assign cq     = r_unit_mev ? CW'(MEV_TO_KELVIN_Q16) : CW'(are_pkg::ONE_Q16);
    assign o_busy = !r_live;
    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attempt_rate   <= 32'd65536000;
            r_barrier_energy <= 32'd65536000;
            r_unit_mev       <= 1'b0;
            r_live           <= 1'b0;
        end else begin
            r_live <= 1'b1;
            if (i_cfg_we) begin
                case (are_pkg::t_cfg_idx'(i_cfg_index))
                    are_pkg::CFG_ATTEMPT_RATE:   r_attempt_rate   <= i_cfg_data;
                    are_pkg::CFG_BARRIER_ENERGY: r_barrier_energy <= i_cfg_data;
                    are_pkg::CFG_UNIT_MEV:       r_unit_mev       <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Front stages: barrier product, then overflow check and divider setup.
    logic          r_s0_valid, r_s1_valid;
    logic [51:0]   r_s0_p;
    logic [31:0]   r_s0_t, r_s1_t;
    logic          r_s1_zero, r_s1_ovf;
    logic [31:0]   r_s1_rem;
    logic [Q1-1:0] r_s1_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s0_valid <= accept;
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_p    <= 52'(r_barrier_energy) * 52'(cq);
        r_s0_t    <= i_temperature;
        r_s1_t    <= r_s0_t;
        r_s1_zero <= (r_s0_t == 32'd0);
        r_s1_ovf  <= ({1'b0, r_s0_p} >= {r_s0_t, 21'd0});
        r_s1_rem  <= {1'b0, r_s0_p[51:21]};
        r_s1_word <= {r_s0_p[20:0], 16'd0};
    end

    // Divider chain for the exponent x = B*c*2^16 / T.
    logic          d1_valid [0:Q1];
    logic [31:0]   d1_rem   [0:Q1];
    logic [31:0]   d1_div   [0:Q1];
    logic [Q1-1:0] d1_word  [0:Q1];
    logic [1:0]    d1_side  [0:Q1];

    assign d1_valid[0] = r_s1_valid;
    assign d1_rem[0]   = r_s1_rem;
    assign d1_div[0]   = r_s1_t;
    assign d1_word[0]  = r_s1_word;
    assign d1_side[0]  = {r_s1_zero, r_s1_ovf};

    for (genvar g = 0; g < Q1; g++) begin : g_div1
        are_div_cell #(.QW(Q1), .SW(2)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (d1_valid[g]),
            .i_rem   (d1_rem[g]),
            .i_div   (d1_div[g]),
            .i_word  (d1_word[g]),
            .i_side  (d1_side[g]),
            .o_valid (d1_valid[g+1]),
            .o_rem   (d1_rem[g+1]),
            .o_div   (d1_div[g+1]),
            .o_word  (d1_word[g+1]),
            .o_side  (d1_side[g+1])
        );
    end

    // Reduction chain: x = n*ln2 + f.
    logic           rd_valid [0:NR];
    logic [XW-1:0]  rd_x     [0:NR];
    logic [NW-1:0]  rd_n     [0:NR];
    logic [RSW-1:0] rd_side  [0:NR];

    assign rd_valid[0] = d1_valid[Q1];
    assign rd_x[0]     = d1_word[Q1];
    assign rd_n[0]     = '0;
    assign rd_side[0]  = {d1_div[Q1], d1_side[Q1]};

    for (genvar g = 0; g < NR; g++) begin : g_red
        are_red_cell #(.J(NR - 1 - g), .SW(RSW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (rd_valid[g]),
            .i_x     (rd_x[g]),
            .i_n     (rd_n[g]),
            .i_side  (rd_side[g]),
            .o_valid (rd_valid[g+1]),
            .o_x     (rd_x[g+1]),
            .o_n     (rd_n[g+1]),
            .o_side  (rd_side[g+1])
        );
    end

    // Series chain for exp(-f).
    logic           se_valid [0:NT];
    logic [31:0]    se_f     [0:NT];
    logic [32:0]    se_term  [0:NT];
    logic [32:0]    se_sum   [0:NT];
    logic [SSW-1:0] se_side  [0:NT];

    assign se_valid[0] = rd_valid[NR];
    assign se_f[0]     = rd_x[NR][31:0];
    assign se_term[0]  = 33'h1_0000_0000;
    assign se_sum[0]   = 33'h1_0000_0000;
    assign se_side[0]  = {rd_n[NR], rd_side[NR]};

    for (genvar g = 0; g < NT; g++) begin : g_series
        are_series_cell #(.K(g + 1), .SW(SSW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (se_valid[g]),
            .i_f     (se_f[g]),
            .i_term  (se_term[g]),
            .i_sum   (se_sum[g]),
            .i_side  (se_side[g]),
            .o_valid (se_valid[g+1]),
            .o_f     (se_f[g+1]),
            .o_term  (se_term[g+1]),
            .o_sum   (se_sum[g+1]),
            .o_side  (se_side[g+1])
        );
    end

    // Back stages: scale by 2^-n, multiply by A, form the slope numerator.
    logic [NW-1:0] se_n;
    logic [31:0]   se_t;
    logic          se_zero, se_ovf;
    logic [64:0]   rate_prod;
    logic [52:0]   m_hi_prod;
    logic [64:0]   m_lo_prod;

    assign se_n    = se_side[NT][SSW-1:34];
    assign se_t    = se_side[NT][33:2];
    assign se_zero = se_side[NT][1];
    assign se_ovf  = se_side[NT][0];

    logic          r_e_valid, r_y_valid, r_z_valid, r_w_valid;
    logic [32:0]   r_e_e, r_y_e;
    logic [31:0]   r_e_t, r_y_t, r_z_t, r_w_t;
    logic          r_e_zero, r_y_zero, r_z_zero, r_w_zero;
    logic [31:0]   r_y_rate, r_z_rate, r_w_rate;
    logic [31:0]   r_y_ef, r_z_ef, r_w_ef;
    logic [51:0]   r_y_m;
    logic [52:0]   r_z_s;
    logic          r_w_ovf;
    logic [31:0]   r_w_rem;
    logic [Q2-1:0] r_w_word;

    always_comb begin
        rate_prod = 65'(r_attempt_rate) * 65'(r_e_e);
        m_hi_prod = 53'(r_y_m[51:32]) * 53'(r_y_e);
        m_lo_prod = 65'(r_y_m[31:0]) * 65'(r_y_e);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_y_valid <= 1'b0;
            r_z_valid <= 1'b0;
            r_w_valid <= 1'b0;
        end else begin
            r_e_valid <= se_valid[NT];
            r_y_valid <= r_e_valid;
            r_z_valid <= r_y_valid;
            r_w_valid <= r_z_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_e    <= se_ovf ? 33'd0 : (se_sum[NT] >> se_n);
        r_e_t    <= se_t;
        r_e_zero <= se_zero;

        r_y_e    <= r_e_e;
        r_y_rate <= rate_prod[63:32];
        r_y_ef   <= r_e_e[32] ? 32'hFFFF_FFFF : r_e_e[31:0];
        r_y_m    <= 52'(r_attempt_rate) * 52'(cq);
        r_y_t    <= r_e_t;
        r_y_zero <= r_e_zero;

        r_z_s    <= m_hi_prod + 53'(m_lo_prod[64:32]);
        r_z_rate <= r_y_rate;
        r_z_ef   <= r_y_ef;
        r_z_t    <= r_y_t;
        r_z_zero <= r_y_zero;

        r_w_ovf  <= ({27'd0, r_z_s} >= {r_z_t, 48'd0});
        r_w_rem  <= {27'd0, r_z_s[52:48]};
        r_w_word <= r_z_s[47:0];
        r_w_t    <= r_z_t;
        r_w_rate <= r_z_rate;
        r_w_ef   <= r_z_ef;
        r_w_zero <= r_z_zero;
    end

    // Divider chain for the slope magnitude s / T.
    logic           d2_valid [0:Q2];
    logic [31:0]    d2_rem   [0:Q2];
    logic [31:0]    d2_div   [0:Q2];
    logic [Q2-1:0]  d2_word  [0:Q2];
    logic [DSW-1:0] d2_side  [0:Q2];

    assign d2_valid[0] = r_w_valid;
    assign d2_rem[0]   = r_w_rem;
    assign d2_div[0]   = r_w_t;
    assign d2_word[0]  = r_w_word;
    assign d2_side[0]  = {r_w_rate, r_w_ef, r_w_zero, r_w_ovf};

    for (genvar g = 0; g < Q2; g++) begin : g_div2
        are_div_cell #(.QW(Q2), .SW(DSW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (d2_valid[g]),
            .i_rem   (d2_rem[g]),
            .i_div   (d2_div[g]),
            .i_word  (d2_word[g]),
            .i_side  (d2_side[g]),
            .o_valid (d2_valid[g+1]),
            .o_rem   (d2_rem[g+1]),
            .o_div   (d2_div[g+1]),
            .o_word  (d2_word[g+1]),
            .o_side  (d2_side[g+1])
        );
    end

    // Output register: saturate the slope and force zeros for zero T.
    localparam logic [47:0] MAG_MAX = 48'h8000_0000_0000;

    logic          d2_zero, d2_ovf;
    logic [47:0]   mag;

    assign d2_zero = d2_side[Q2][1];
    assign d2_ovf  = d2_side[Q2][0];
    assign mag     = (d2_ovf || d2_word[Q2] > MAG_MAX) ? MAG_MAX : d2_word[Q2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= d2_valid[Q2];
        end
    end

    always_ff @(posedge i_clk) begin
        o_zero_temp_flag <= d2_zero;
        o_rate_value     <= d2_zero ? 32'd0 : d2_side[Q2][65:34];
        o_exp_factor     <= d2_zero ? 32'd0 : d2_side[Q2][33:2];
        o_barrier_slope  <= d2_zero ? 48'sd0 : $signed(48'd0 - mag);
    end

endmodule

### rtl/are_checker.sv
// ----------------------------------------------------------------------------
// Arrhenius rate evaluator checker
// Port-level properties of the rate evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module are_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               o_valid,
    input logic [31:0]        o_rate_value,
    input logic [31:0]        o_exp_factor,
    input logic signed [47:0] o_barrier_slope,
    input logic               o_zero_temp_flag
);

    // Every result word traces back to a word started a fixed time earlier.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, are_pkg::LATENCY))
        else $error("result word without a matching start");

    // A zero temperature forces all results to zero.
    a_zero_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_temp_flag) |->
            (o_rate_value == 32'd0 && o_exp_factor == 32'd0 &&
             o_barrier_slope == 48'sd0))
        else $error("zero temperature gave nonzero results");

    // The barrier derivative is never positive.
    a_slope_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_barrier_slope[47] || o_barrier_slope == 48'sd0))
        else $error("positive barrier slope");

    // A vanished exponential factor means a vanished rate.
    a_rate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_exp_factor == 32'd0) |-> (o_rate_value == 32'd0))
        else $error("nonzero rate with zero exponential factor");

endmodule

bind arrhenius_rate_evaluator are_checker u_are_checker (.*);
